### rtl/cbm_pkg.sv
// cbm_pkg: shared types and constants for the console bank mapper.
// No dependencies; used by cbm_decode and console_bank_mapper_bus_top.
package cbm_pkg;

	localparam int ADDR_W = 16;
	localparam int DATA_W = 8;
	localparam int OP_W   = 2;
	localparam int TGT_W  = 3;
	localparam int MA_W   = 22;
	localparam int BANK_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 1;

	// transaction opcodes
	localparam logic [OP_W-1:0] OP_READ  = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_MEMCTL = 2'd2;

	// decode targets
	localparam logic [TGT_W-1:0] TGT_NONE = 3'd0;
	localparam logic [TGT_W-1:0] TGT_BIOS = 3'd1;
	localparam logic [TGT_W-1:0] TGT_ROM  = 3'd2;
	localparam logic [TGT_W-1:0] TGT_CRAM = 3'd3;
	localparam logic [TGT_W-1:0] TGT_SRAM = 3'd4;

	// config register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_CART_PRESENT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CART_IS_32K  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BIOS_PRESENT = 2'd2;

	// bus map
	localparam logic [ADDR_W-1:0] A_UNBANKED_END = 16'h0400;
	localparam logic [ADDR_W-1:0] A_SLOT1   = 16'h4000;
	localparam logic [ADDR_W-1:0] A_SLOT2   = 16'h8000;
	localparam logic [ADDR_W-1:0] A_SYSRAM  = 16'hC000;
	localparam logic [ADDR_W-1:0] A_MAP_CTL = 16'hFFFC;
	localparam logic [ADDR_W-1:0] A_MAP_B0  = 16'hFFFD;
	localparam logic [ADDR_W-1:0] A_MAP_B1  = 16'hFFFE;
	localparam logic [ADDR_W-1:0] A_MAP_B2  = 16'hFFFF;

	// memory control / mapper control bit positions
	localparam int MC_CART_OFF_BIT = 6;
	localparam int MC_BIOS_OFF_BIT = 3;
	localparam int MAP_RAM_EN_BIT  = 3;
	localparam int MAP_RAM_PG_BIT  = 2;

	typedef struct packed {
		logic              cart_present;
		logic              cart_is_32k;
		logic              cart_slot_on;
		logic              bios_on;
		logic              slot2_is_ram;
		logic              ram_page_sel;
		logic [BANK_W-1:0] bank_slot0;
		logic [BANK_W-1:0] bank_slot1;
		logic [BANK_W-1:0] bank_slot2;
	} map_state_t;

	typedef struct packed {
		logic [TGT_W-1:0] target;
		logic [MA_W-1:0]  mapped_address;
		logic             sram_read;
	} dec_t;

endpackage

### rtl/cbm_ram.sv
// cbm_ram: generic single-port synchronous RAM, registered read.
// No dependencies.
module cbm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8192,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

### rtl/cbm_decode.sv
// cbm_decode: target and mapped address decode for one bus transaction.
// Depends on cbm_pkg.
module cbm_decode
	import cbm_pkg::*;
#(
	parameter int IDX_W      = 13,
	parameter int BIOS_BYTES = 8192
) (
	input  logic [OP_W-1:0]   op,
	input  logic [ADDR_W-1:0] address,
	input  logic [IDX_W-1:0]  ram_index,
	input  map_state_t        map,
	output dec_t              dec
);

	localparam logic [ADDR_W:0] BIOS_LIMIT = (ADDR_W+1)'(BIOS_BYTES);

	logic [MA_W-1:0] slot2_ram_ma;
	logic [MA_W-1:0] sram_ma;
	logic            bios_hit;

	assign slot2_ram_ma = MA_W'({map.ram_page_sel, address[13:0]});
	assign sram_ma      = MA_W'(ram_index);
	assign bios_hit     = map.bios_on && ({1'b0, address} < BIOS_LIMIT);

	always_comb begin
		dec = '{target: TGT_NONE, mapped_address: '0, sram_read: 1'b0};
		case (op)
			OP_READ: begin
				if (bios_hit) begin
					dec.target         = TGT_BIOS;
					dec.mapped_address = MA_W'(address);
				end else if (map.cart_slot_on && !map.cart_present) begin
					dec.target = TGT_NONE;
				end else if (map.cart_slot_on && address < A_UNBANKED_END) begin
					dec.target         = TGT_ROM;
					dec.mapped_address = MA_W'(address);
				end else if (map.cart_slot_on && map.cart_is_32k && address < A_SLOT2) begin
					dec.target         = TGT_ROM;
					dec.mapped_address = MA_W'(address[14:0]);
				end else if (map.cart_slot_on && !map.cart_is_32k && address < A_SYSRAM) begin
					if (address < A_SLOT1) begin
						dec.target         = TGT_ROM;
						dec.mapped_address = {map.bank_slot0, address[13:0]};
					end else if (address < A_SLOT2) begin
						dec.target         = TGT_ROM;
						dec.mapped_address = {map.bank_slot1, address[13:0]};
					end else if (map.slot2_is_ram) begin
						dec.target         = TGT_CRAM;
						dec.mapped_address = slot2_ram_ma;
					end else begin
						dec.target         = TGT_ROM;
						dec.mapped_address = {map.bank_slot2, address[13:0]};
					end
				end else if (address >= A_SYSRAM) begin
					dec.target         = TGT_SRAM;
					dec.mapped_address = sram_ma;
					dec.sram_read      = 1'b1;
				end
			end
			OP_WRITE: begin
				if (address >= A_SYSRAM) begin
					dec.target         = TGT_SRAM;
					dec.mapped_address = sram_ma;
				end else if (address >= A_SLOT2 && map.slot2_is_ram) begin
					dec.target         = TGT_CRAM;
					dec.mapped_address = slot2_ram_ma;
				end
			end
			default: begin
				dec.target = TGT_NONE;
			end
		endcase
	end

endmodule

### rtl/console_bank_mapper_bus_top.sv
// console_bank_mapper_bus_top: CPU bus decoder and bank mapper, system RAM inside.
// Sequencer steps: index multiply, remainder, RAM access, RAM read data, around
//   the single work RAM port; a new transaction is taken only once the last result
//   is loaded into the output register.
// Reset: async, active low; then a clearing pass writes the RAM reset image,
//   during which no input transaction is taken.
// Depends on cbm_pkg, cbm_ram, cbm_decode.
module console_bank_mapper_bus_top
	import cbm_pkg::*;
#(
	parameter int WORK_RAM_BYTES = 8192,
	parameter int BIOS_BYTES     = 8192
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// config write port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// input transaction channel
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [OP_W-1:0]       op,
	input  logic [ADDR_W-1:0]     address,
	input  logic [DATA_W-1:0]     data,
	// result transaction channel
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [TGT_W-1:0]      target,
	output logic [MA_W-1:0]       mapped_address,
	output logic [DATA_W-1:0]     read_data
);

	// RAM index = address mod WORK_RAM_BYTES, done with a reciprocal multiply
	// (exact for 16-bit addresses with a 2^32 scale) plus one fix-up subtract.
	localparam int IDX_W = $clog2(WORK_RAM_BYTES);
	localparam int RW    = 33 - IDX_W;           // reciprocal width
	localparam int PW    = ADDR_W + RW;          // product width
	localparam int QW    = PW - 32;              // quotient width
	localparam longint RECIP_L = ((64'd1 << 32) + WORK_RAM_BYTES - 1) / WORK_RAM_BYTES;
	localparam logic [RW-1:0]     RECIP   = RW'(RECIP_L);
	localparam logic [ADDR_W:0]   RAM_N   = (ADDR_W+1)'(WORK_RAM_BYTES);
	localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(WORK_RAM_BYTES - 1);
	localparam logic [IDX_W-1:0]  IDX_PEN  = IDX_W'(WORK_RAM_BYTES - 2);

	// sequencer states
	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_MUL   = 3'd2;
	localparam logic [2:0] ST_REM   = 3'd3;
	localparam logic [2:0] ST_MEM   = 3'd4;
	localparam logic [2:0] ST_DONE  = 3'd5;

	logic [2:0]        state_q;
	logic [IDX_W-1:0]  clr_idx_q;

	// captured transaction
	logic [OP_W-1:0]   op_s1;
	logic [ADDR_W-1:0] address_s1;
	logic [DATA_W-1:0] data_s1;

	logic [PW-1:0]     prod_s2;
	logic [IDX_W-1:0]  idx_s3;
	dec_t              dec_s4;

	// mapper state
	map_state_t        map_q;

	// output register
	logic              out_valid_q;
	logic [TGT_W-1:0]  target_q;
	logic [MA_W-1:0]   mapped_address_q;
	logic [DATA_W-1:0] read_data_q;

	// RAM port
	logic              ram_we;
	logic [IDX_W-1:0]  ram_addr;
	logic [DATA_W-1:0] ram_wdata;
	logic [DATA_W-1:0] ram_rdata;

	// remainder path
	logic [QW-1:0]     quot;
	logic [ADDR_W:0]   rem_raw;
	logic [ADDR_W:0]   rem_fix;

	dec_t              dec;
	logic              wr_sram;
	logic              out_load;

	assign quot    = prod_s2[PW-1:32];
	assign rem_raw = {1'b0, address_s1} - (ADDR_W+1)'((ADDR_W+1)'(quot) * RAM_N);
	assign rem_fix = (rem_raw >= RAM_N) ? (rem_raw - RAM_N) : rem_raw;

	cbm_decode #(
		.IDX_W      (IDX_W),
		.BIOS_BYTES (BIOS_BYTES)
	) u_decode (
		.op        (op_s1),
		.address   (address_s1),
		.ram_index (idx_s3),
		.map       (map_q),
		.dec       (dec)
	);

	// system RAM write: op write at 0xC000 and above, issued in the MEM step
	assign wr_sram = (state_q == ST_MEM) && (op_s1 == OP_WRITE) && (address_s1 >= A_SYSRAM);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we   = 1'b1;
			ram_addr = clr_idx_q;
			if (clr_idx_q == IDX_LAST) begin
				ram_wdata = DATA_W'(2);
			end else if (clr_idx_q == IDX_PEN) begin
				ram_wdata = DATA_W'(1);
			end else begin
				ram_wdata = '0;
			end
		end else begin
			ram_we    = wr_sram;
			ram_addr  = idx_s3;
			ram_wdata = data_s1;
		end
	end

	cbm_ram #(
		.WIDTH (DATA_W),
		.DEPTH (WORK_RAM_BYTES)
	) u_work_ram (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign in_ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_idx_q <= clr_idx_q + IDX_W'(1);
					if (clr_idx_q == IDX_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL:  state_q <= ST_REM;
				ST_REM:  state_q <= ST_MEM;
				ST_MEM:  state_q <= ST_DONE;
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_CLEAR;
			endcase
		end
	end

	// datapath pipeline registers (no reset needed)
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= op;
			address_s1 <= address;
			data_s1    <= data;
		end
		if (state_q == ST_MUL) begin
			prod_s2 <= PW'(address_s1) * PW'(RECIP);
		end
		if (state_q == ST_REM) begin
			idx_s3 <= rem_fix[IDX_W-1:0];
		end
		if (state_q == ST_MEM) begin
			dec_s4 <= dec;   // sampled against mapper state before this write lands
		end
	end

	// mapper state: config port, memory control and mapper register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_q.cart_present <= 1'b0;
			map_q.cart_is_32k  <= 1'b0;
			map_q.cart_slot_on <= 1'b1;
			map_q.bios_on      <= 1'b0;
			map_q.slot2_is_ram <= 1'b0;
			map_q.ram_page_sel <= 1'b0;
			map_q.bank_slot0   <= BANK_W'(0);
			map_q.bank_slot1   <= BANK_W'(1);
			map_q.bank_slot2   <= BANK_W'(2);
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CART_PRESENT: map_q.cart_present <= cfg_data[0];
					CFG_CART_IS_32K:  map_q.cart_is_32k  <= cfg_data[0];
					CFG_BIOS_PRESENT: map_q.bios_on      <= cfg_data[0];
					default: ;
				endcase
			end
			if (state_q == ST_MEM && op_s1 == OP_MEMCTL) begin
				map_q.cart_slot_on <= !data_s1[MC_CART_OFF_BIT];
				map_q.bios_on      <= !data_s1[MC_BIOS_OFF_BIT];
			end
			if (wr_sram) begin
				unique case (address_s1)
					A_MAP_CTL: begin
						map_q.slot2_is_ram <= data_s1[MAP_RAM_EN_BIT];
						if (data_s1[MAP_RAM_EN_BIT]) begin
							map_q.ram_page_sel <= data_s1[MAP_RAM_PG_BIT];
						end
					end
					A_MAP_B0: map_q.bank_slot0 <= data_s1;
					A_MAP_B1: map_q.bank_slot1 <= data_s1;
					A_MAP_B2: begin
						if (!map_q.slot2_is_ram) begin
							map_q.bank_slot2 <= data_s1;
						end
					end
					default: ;
				endcase
			end
		end
	end

	// output register; RAM read data lands in the DONE step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			target_q         <= dec_s4.target;
			mapped_address_q <= dec_s4.mapped_address;
			read_data_q      <= dec_s4.sram_read ? ram_rdata : '0;
		end
	end

	assign out_valid      = out_valid_q;
	assign target         = target_q;
	assign mapped_address = mapped_address_q;
	assign read_data      = read_data_q;

endmodule

### sim/cbm_checker.sv
`timescale 1ns / 100ps
// cbm_checker: tracks the console bank mapper state from the config port and input channel,
// predicts every result transaction and compares it field by field. Depends on cbm_pkg.
module cbm_checker
	import cbm_pkg::*;
#(
	parameter int WORK_RAM_BYTES = 8192,
	parameter int BIOS_BYTES     = 8192
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  in_valid,
	input  logic                  in_ready,
	input  logic [OP_W-1:0]       op,
	input  logic [ADDR_W-1:0]     address,
	input  logic [DATA_W-1:0]     data,
	input  logic                  out_valid,
	input  logic                  out_ready,
	input  logic [TGT_W-1:0]      target,
	input  logic [MA_W-1:0]       mapped_address,
	input  logic [DATA_W-1:0]     read_data,
	output int                    mismatch_count,
	output int                    results_due,
	output int                    results_checked
);

	typedef struct packed {
		logic [TGT_W-1:0]  target;
		logic [MA_W-1:0]   mapped_address;
		logic [DATA_W-1:0] read_data;
	} access_result_t;

	access_result_t    decoded_queue[$];
	logic [DATA_W-1:0] sys_ram[WORK_RAM_BYTES];
	logic              have_cart, flat_rom, slot_on, bios_on, slot2_ram, ram_page;
	logic [BANK_W-1:0] bank0, bank1, bank2;
	int                mismatch_total = 0;
	int                checked_total  = 0;
	int                due_total      = 0;

	assign mismatch_count  = mismatch_total;
	assign results_due     = due_total;
	assign results_checked = checked_total;

	function automatic logic [MA_W-1:0] rom_at(input logic [BANK_W-1:0] bank,
			input logic [ADDR_W-1:0] offs);
		return {bank, 14'd0} + MA_W'(offs);
	endfunction

	function automatic logic [MA_W-1:0] cart_ram_at(input logic [ADDR_W-1:0] a);
		return (MA_W'(ram_page) << 14) + MA_W'(a - A_SLOT2);
	endfunction

	function automatic access_result_t decode_read(input logic [ADDR_W-1:0] a);
		access_result_t r;
		int idx;
		r = '0;
		if (int'(a) < BIOS_BYTES && bios_on) begin
			r.target = TGT_BIOS;
			r.mapped_address = MA_W'(int'(a) % BIOS_BYTES);
			return r;
		end
		if (slot_on) begin
			// enabled slot with no cartridge swallows the whole bus
			if (!have_cart)
				return r;
			if (a < A_UNBANKED_END) begin
				r.target = TGT_ROM;
				r.mapped_address = MA_W'(a);
				return r;
			end
			if (flat_rom) begin
				if (a < A_SLOT2) begin
					r.target = TGT_ROM;
					r.mapped_address = MA_W'(a);
					return r;
				end
			end else if (a < A_SLOT1) begin
				r.target = TGT_ROM;
				r.mapped_address = rom_at(bank0, a);
				return r;
			end else if (a < A_SLOT2) begin
				r.target = TGT_ROM;
				r.mapped_address = rom_at(bank1, a - A_SLOT1);
				return r;
			end else if (a < A_SYSRAM) begin
				if (slot2_ram) begin
					r.target = TGT_CRAM;
					r.mapped_address = cart_ram_at(a);
				end else begin
					r.target = TGT_ROM;
					r.mapped_address = rom_at(bank2, a - A_SLOT2);
				end
				return r;
			end
		end
		if (a >= A_SYSRAM) begin
			idx = int'(a) % WORK_RAM_BYTES;
			r.target = TGT_SRAM;
			r.mapped_address = MA_W'(idx);
			r.read_data = sys_ram[idx];
		end
		return r;
	endfunction

	function automatic access_result_t apply_write(input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		access_result_t r;
		int idx;
		r = '0;
		if (a < A_SLOT2)
			return r;
		if (a < A_SYSRAM) begin
			// cart RAM write ignores cart presence and slot enable
			if (slot2_ram) begin
				r.target = TGT_CRAM;
				r.mapped_address = cart_ram_at(a);
			end
			return r;
		end
		idx = int'(a) % WORK_RAM_BYTES;
		sys_ram[idx] = d;
		r.target = TGT_SRAM;
		r.mapped_address = MA_W'(idx);
		case (a)
			A_MAP_CTL: begin
				if (d[MAP_RAM_EN_BIT]) begin
					slot2_ram = 1'b1;
					ram_page = d[MAP_RAM_PG_BIT];
				end else begin
					slot2_ram = 1'b0;
				end
			end
			A_MAP_B0: bank0 = d;
			A_MAP_B1: bank1 = d;
			A_MAP_B2: if (!slot2_ram) bank2 = d;
			default: ;
		endcase
		return r;
	endfunction

	task automatic flag(input string what, input logic [31:0] want, input logic [31:0] got);
		mismatch_total++;
		if (mismatch_total <= 100)
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		access_result_t seen, want;
		if (!arst_n) begin
			foreach (sys_ram[i]) sys_ram[i] = '0;
			sys_ram[WORK_RAM_BYTES-2] = 8'd1;
			sys_ram[WORK_RAM_BYTES-1] = 8'd2;
			have_cart = 1'b0;
			flat_rom  = 1'b0;
			bios_on   = 1'b0;
			slot_on   = 1'b1;
			slot2_ram = 1'b0;
			ram_page  = 1'b0;
			bank0     = 8'd0;
			bank1     = 8'd1;
			bank2     = 8'd2;
			decoded_queue.delete();
		end else begin
			// results first, so an input taken on the same edge is never matched early
			if (out_valid && out_ready) begin
				seen.target = target;
				seen.mapped_address = mapped_address;
				seen.read_data = read_data;
				if (decoded_queue.size() == 0) begin
					flag("unexpected result (target/address/data)",
						{seen.target, 29'd0}, {seen.target, 7'd0, seen.mapped_address});
				end else begin
					want = decoded_queue.pop_front();
					checked_total++;
					if (seen.target !== want.target)
						flag("target", want.target, seen.target);
					if (seen.mapped_address !== want.mapped_address)
						flag("mapped_address", want.mapped_address, seen.mapped_address);
					if (seen.read_data !== want.read_data)
						flag("read_data", want.read_data, seen.read_data);
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_CART_PRESENT: have_cart = cfg_data[0];
					CFG_CART_IS_32K:  flat_rom = cfg_data[0];
					CFG_BIOS_PRESENT: bios_on = cfg_data[0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				case (op)
					OP_READ:  decoded_queue.push_back(decode_read(address));
					OP_WRITE: decoded_queue.push_back(apply_write(address, data));
					OP_MEMCTL: begin
						slot_on = !data[MC_CART_OFF_BIT];
						bios_on = !data[MC_BIOS_OFF_BIT];
						decoded_queue.push_back('0);
					end
					default: decoded_queue.push_back('0);
				endcase
			end
		end
		due_total = decoded_queue.size();
	end

endmodule

### sim/testbench.sv
`timescale 1ns / 100ps
// testbench: stimulus and verdict for console_bank_mapper_bus_top.
// Depends on cbm_pkg, the RTL, and cbm_checker (prediction and comparison).
module testbench;
	import cbm_pkg::*;

	localparam int WORK_RAM_BYTES = 8192;
	localparam int BIOS_BYTES     = 8192;
	localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
	// clearing pass plus ~870 transactions with stalls, many times over
	localparam int CYCLE_LIMIT       = 200000;
	localparam int RESULT_LATENCY    = 4;
	localparam int ITEMS_PER_SETTING = 140;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_ready;
	logic [OP_W-1:0]       op = OP_READ;
	logic [ADDR_W-1:0]     address = '0;
	logic [DATA_W-1:0]     data = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	logic [TGT_W-1:0]      target;
	logic [MA_W-1:0]       mapped_address;
	logic [DATA_W-1:0]     read_data;

	// steady: both sides stop idling (one full mapper setting runs this way)
	logic              steady = 1'b0;
	int                mismatch_count, results_due, results_checked;
	int                op_count[4] = '{default: 0};
	int                settings_done = 0;
	int                cycles = 0;
	// recently written system RAM addresses, read back to catch store/mirror bugs
	logic [ADDR_W-1:0] recent_writes[$];

	console_bank_mapper_bus_top #(
		.WORK_RAM_BYTES(WORK_RAM_BYTES),
		.BIOS_BYTES(BIOS_BYTES)
	) uut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .address(address), .data(data),
		.out_valid(out_valid), .out_ready(out_ready),
		.target(target), .mapped_address(mapped_address), .read_data(read_data)
	);

	cbm_checker #(
		.WORK_RAM_BYTES(WORK_RAM_BYTES),
		.BIOS_BYTES(BIOS_BYTES)
	) map_check (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready),
		.op(op), .address(address), .data(data),
		.out_valid(out_valid), .out_ready(out_ready),
		.target(target), .mapped_address(mapped_address), .read_data(read_data),
		.mismatch_count(mismatch_count), .results_due(results_due),
		.results_checked(results_checked)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side backpressure: ~7% stall cycles unless in the steady stretch
	always @(negedge clk) begin
		out_ready <= steady || ($urandom_range(0, 99) >= 7);
	end

	// watchdog
	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("%0t: timeout after %0d cycles, %0d results outstanding",
			$time, CYCLE_LIMIT, results_due);
		$display("FAIL");
		$finish;
	end

	// One input transaction. Gaps go in before valid rises; once high, valid and
	// payload hold until the acceptance edge. Next call or settle() changes them
	// at the following falling edge, so each signal sees one assignment per step.
	task automatic send_item(input logic [OP_W-1:0] k, input logic [ADDR_W-1:0] a,
			input logic [DATA_W-1:0] d);
		@(negedge clk);
		while (!steady && $urandom_range(0, 99) < 7) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		op <= k;
		address <= a;
		data <= d;
		do @(posedge clk); while (!in_ready);
		op_count[k]++;
	endtask

	// Drop valid, wait for every predicted result, then let the pipe drain.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due != 0) @(negedge clk);
		repeat (RESULT_LATENCY + 2) @(negedge clk);
	endtask

	// Writes all three config registers back to back; called with no transaction in flight.
	task automatic set_mapper(input logic cp, input logic c32, input logic bp);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_CART_PRESENT;
		cfg_data <= cp;
		@(negedge clk);
		cfg_index <= CFG_CART_IS_32K;
		cfg_data <= c32;
		@(negedge clk);
		cfg_index <= CFG_BIOS_PRESENT;
		cfg_data <= bp;
		@(negedge clk);
		cfg_we <= 1'b0;
		settings_done++;
	endtask

	// Address weighted by bus region, mapper registers included.
	function automatic logic [ADDR_W-1:0] pick_address();
		int w;
		w = $urandom_range(0, 99);
		if (w < 10) return ADDR_W'($urandom_range(0, A_UNBANKED_END - 1));
		if (w < 20) return ADDR_W'($urandom_range(A_UNBANKED_END, BIOS_BYTES - 1));
		if (w < 30) return ADDR_W'($urandom_range(BIOS_BYTES, A_SLOT1 - 1));
		if (w < 45) return ADDR_W'($urandom_range(A_SLOT1, A_SLOT2 - 1));
		if (w < 65) return ADDR_W'($urandom_range(A_SLOT2, A_SYSRAM - 1));
		if (w < 90) return ADDR_W'($urandom_range(A_SYSRAM, A_MAP_CTL - 1));
		return ADDR_W'($urandom_range(A_MAP_CTL, A_MAP_B2));
	endfunction

	// Mostly bus reads/writes; a few memory-control writes and unused opcodes.
	task automatic random_access();
		int               w;
		logic [OP_W-1:0]  k;
		logic [ADDR_W-1:0] a;
		logic [DATA_W-1:0] d;
		w = $urandom_range(0, 99);
		d = DATA_W'($urandom);
		if (w < 2) k = OP_UNUSED;
		else if (w < 10) k = OP_MEMCTL;
		else if (w < 55) k = OP_READ;
		else k = OP_WRITE;
		a = pick_address();
		if (k == OP_READ && recent_writes.size() > 0 && $urandom_range(0, 3) == 0)
			a = recent_writes[$urandom_range(0, recent_writes.size() - 1)];
		if (k == OP_WRITE && a >= A_SYSRAM) begin
			recent_writes.push_back(a);
			if (recent_writes.size() > 16)
				void'(recent_writes.pop_front());
		end
		send_item(k, a, d);
	endtask

	initial begin
		// {cart_present, cart_is_32k, bios_present} per random phase
		logic [2:0] phase_cfg[6];
		phase_cfg = '{3'b100, 3'b101, 3'b000, 3'b110, 3'b011, 3'b111};

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Config goes in while the RAM clearing pass runs; inputs wait on ready.
		set_mapper(1'b1, 1'b0, 1'b1);

		// Directed: BIOS overlay, reset image of RAM, unbanked start, the three
		// slots, mapper registers, cart RAM on and off, ignored writes, mirror,
		// memory control, unused opcode.
		send_item(OP_READ, 16'h0000, 8'h00);
		send_item(OP_READ, 16'h1FFF, 8'hFF);
		send_item(OP_READ, 16'hFFFF, 8'h00);   // reset image holds 2 here
		send_item(OP_READ, 16'hDFFD, 8'h00);   // and 0 here
		send_item(OP_MEMCTL, 16'h0000, 8'h08); // BIOS off, cart slot on
		send_item(OP_READ, 16'h0000, 8'h00);
		send_item(OP_READ, 16'h03FF, 8'h00);
		send_item(OP_READ, 16'h0400, 8'h00);
		send_item(OP_READ, 16'h7FFF, 8'h00);
		send_item(OP_READ, 16'h8000, 8'h00);
		send_item(OP_WRITE, A_MAP_B0, 8'hFF);
		send_item(OP_WRITE, A_MAP_B1, 8'h80);
		send_item(OP_WRITE, A_MAP_B2, 8'h3F);
		send_item(OP_READ, 16'h3FFF, 8'h00);
		send_item(OP_READ, 16'hBFFF, 8'h00);
		send_item(OP_WRITE, A_MAP_CTL, 8'h0C); // cart RAM, page 1
		send_item(OP_WRITE, A_MAP_B2, 8'h12);  // bank 2 locked while RAM is mapped
		send_item(OP_WRITE, A_SLOT2, 8'hFF);
		send_item(OP_READ, 16'hBFFF, 8'h00);
		send_item(OP_WRITE, A_MAP_CTL, 8'hF7); // RAM off, page kept
		send_item(OP_WRITE, 16'hA000, 8'h55);  // slot 2 write with ROM mapped: none
		send_item(OP_WRITE, 16'h7FFF, 8'hAA);  // low write ignored
		send_item(OP_WRITE, A_SYSRAM, 8'hFF);
		send_item(OP_READ, 16'hE000, 8'h00);   // mirror of 0xC000
		send_item(OP_MEMCTL, 16'hFFFF, 8'h40); // cart off, BIOS on
		send_item(OP_READ, 16'h8000, 8'h00);   // hits nothing
		send_item(OP_MEMCTL, 16'h0000, 8'h48); // both off
		send_item(OP_READ, 16'h2000, 8'h00);
		send_item(OP_UNUSED, A_MAP_CTL, 8'hFF);
		send_item(OP_MEMCTL, 16'h0000, 8'h00);
		settle();

		// Random phases, one per mapper setting; the second runs with no idling.
		foreach (phase_cfg[p]) begin
			set_mapper(phase_cfg[p][2], phase_cfg[p][1], phase_cfg[p][0]);
			steady <= (p == 1);
			repeat (ITEMS_PER_SETTING) random_access();
			settle();
		end

		$display("Covered %0d reads, %0d bus writes, %0d memory-control and %0d unused-op transactions",
			op_count[OP_READ], op_count[OP_WRITE], op_count[OP_MEMCTL], op_count[OP_UNUSED]);
		$display("under %0d mapper settings; %0d result transactions compared",
			settings_done, results_checked);
		if (results_due != 0)
			$display("%0t: %0d expected results never arrived", $time, results_due);
		if (mismatch_count == 0 && results_due == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
